@@ rtl/ggd_pkg.sv @@
// ----------------------------------------------------------------------------
// ggd_pkg
// Shared types and constants of the generalized-Gaussian sample transform.
// ----------------------------------------------------------------------------
package ggd_pkg;

	// Width of the signed sample and its largest magnitude.
	localparam int SAMPLE_W = 48;
	localparam logic [46:0] MAG_MAX = {47{1'b1}};

	// Fraction bits of the base-2 logarithm produced by repeated squaring.
	localparam int LOG_FRAC = 28;

	// ln(2) in Q0.30, rounded.
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	// Register stages of the logarithm unit: encode, normalize, one per
	// squaring step, product and rounding.
	localparam int LN_LAT = LOG_FRAC + 4;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_SHAPE_MODE = 1'b0,
		CFG_SCALE      = 1'b1
	} cfg_reg_e;

	// One input request.
	typedef struct packed {
		logic [31:0] uniform_a;
		logic [31:0] uniform_b;
		logic        sign_bit;
		logic        last_sample;
	} in_item_t;

	// One result request.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       saturated;
		logic                       last_out;
	} out_item_t;

endpackage

@@ rtl/ggd_neg_ln.sv @@
// ----------------------------------------------------------------------------
// ggd_neg_ln
// Pipelined -ln(1-u) of a uniform word, rounded to FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module ggd_neg_ln #(
	parameter int FRAC_BITS    = 16,
	parameter int UNIFORM_BITS = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [31:0]          word,
	output logic [FRAC_BITS+4:0] neg_ln
);
	import ggd_pkg::*;

	localparam int MW = UNIFORM_BITS + 1;
	localparam int EW = $clog2(MW);
	localparam int NW = FRAC_BITS + 5;
	localparam int VW = LOG_FRAC + 6;
	localparam int PW = VW + 30;
	localparam int RW = PW + 1;

	logic [MW-1:0]       m_c;
	logic [EW-1:0]       e_c;
	logic [MW-1:0]       m_s1;
	logic [EW-1:0]       e_s1;
	logic [MW+29:0]      wide_c;
	logic [30:0]         f_p    [0:LOG_FRAC];
	logic [LOG_FRAC-1:0] bits_p [0:LOG_FRAC];
	logic [EW-1:0]       e_p    [0:LOG_FRAC];
	logic [VW-1:0]       v_c;
	logic [PW-1:0]       prod_s;
	logic [RW-1:0]       rnd_c;
	logic [NW-1:0]       ln_s;

	// Stage 1: m = 2^UNIFORM_BITS - k and the position of its leading one.
	always_comb begin
		m_c = (MW'(1) << UNIFORM_BITS) - MW'(word[31 -: UNIFORM_BITS]);
		e_c = '0;
		for (int i = 0; i < MW; i++) begin
			if (m_c[i]) begin
				e_c = EW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= m_c;
			e_s1 <= e_c;
		end
	end

	// Stage 2: normalize m to Q1.30, truncating when it is wider.
	assign wide_c = {m_s1, 30'b0} >> e_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			f_p[0]    <= wide_c[30:0];
			bits_p[0] <= '0;
			e_p[0]    <= e_s1;
		end
	end

	// One squaring step per stage; each yields one bit of log2 f.
	for (genvar j = 0; j < LOG_FRAC; j++) begin : g_sq
		logic [61:0] sq_c;
		logic [31:0] t_c;

		always_comb begin
			sq_c = 62'(f_p[j]) * 62'(f_p[j]);
			t_c  = sq_c[61:30];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				f_p[j+1]    <= t_c[31] ? t_c[31:1] : t_c[30:0];
				bits_p[j+1] <= {bits_p[j][LOG_FRAC-2:0], t_c[31]};
				e_p[j+1]    <= e_p[j];
			end
		end
	end

	// Product stage: (UNIFORM_BITS - e - log2 f) times ln 2.
	always_comb begin
		v_c = ((VW'(UNIFORM_BITS) - VW'(e_p[LOG_FRAC])) << LOG_FRAC)
			- VW'(bits_p[LOG_FRAC]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s <= PW'(v_c) * PW'(LN2_Q30);
		end
	end

	// Rounding stage: nearest, ties up, to FRAC_BITS fraction bits.
	assign rnd_c = RW'(prod_s) + (RW'(1) << (57 - FRAC_BITS));

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s <= rnd_c[58-FRAC_BITS +: NW];
		end
	end

	assign neg_ln = ln_s;

endmodule

@@ rtl/ggd_sample_transform.sv @@
// ----------------------------------------------------------------------------
// ggd_sample_transform
// Inverse-transform generator of Laplace and shape-0.5 generalized-Gaussian
// samples from uniform words.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; the 28 squaring stages of each
// logarithm unit and the split squaring of the tail are fully pipelined.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and loads shape_mode = 0 and scale = 1.0.
module ggd_sample_transform #(
	parameter int FRAC_BITS    = 16,
	parameter int UNIFORM_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ggd_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ggd_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [23:0]         cfg_data
);
	import ggd_pkg::*;

	localparam int N   = LN_LAT + 5;
	localparam int NW  = FRAC_BITS + 5;
	localparam int SW  = FRAC_BITS + 6;
	localparam int MPW = SW + 24;
	localparam int YW  = FRAC_BITS + 14;
	localparam int HL  = (YW + 1) / 2;
	localparam int HH  = YW - HL;
	localparam int QW  = (2 * YW + 1 > FRAC_BITS + 48) ? 2 * YW + 1 : FRAC_BITS + 48;
	localparam int RQW = QW - FRAC_BITS;

	logic                shape_mode_q;
	logic [23:0]         scale_q;
	logic                adv;
	logic [N-1:0]        valid_s;
	logic [N-2:0]        sign_s;
	logic [N-2:0]        last_s;
	logic [NW-1:0]       na;
	logic [NW-1:0]       nb;
	logic [SW-1:0]       sum_s1;
	logic [MPW-1:0]      scl_c;
	logic [YW-1:0]       y_s2;
	logic [YW-1:0]       y_s3;
	logic [2*HH-1:0]     hh_s3;
	logic [HH+HL-1:0]    hl_s3;
	logic [2*HL-1:0]     ll_s3;
	logic [YW-1:0]       y_s4;
	logic [QW-1:0]       sq_s4;
	logic [RQW-1:0]      r_c;
	logic                sat_c;
	logic [46:0]         mag_c;
	out_item_t           out_s5;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_mode_q <= 1'b0;
			scale_q      <= 24'd65536;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				CFG_SHAPE_MODE: shape_mode_q <= cfg_data[0];
				CFG_SCALE:      scale_q      <= cfg_data;
				default:        shape_mode_q <= shape_mode_q;
			endcase
		end
	end

	// The whole pipeline moves unless a result is held by the output.
	assign adv      = !valid_s[N-1] || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[N-2:0], in_valid};
		end
	end

	// Sign and batch mark ride alongside the data.
	always_ff @(posedge clk) begin
		if (adv) begin
			sign_s <= {sign_s[N-3:0], in_data.sign_bit};
			last_s <= {last_s[N-3:0], in_data.last_sample};
		end
	end

	// Logarithm lanes for both uniform words.
	ggd_neg_ln #(
		.FRAC_BITS    (FRAC_BITS),
		.UNIFORM_BITS (UNIFORM_BITS)
	) u_ln_a (
		.clk    (clk),
		.en     (adv),
		.word   (in_data.uniform_a),
		.neg_ln (na)
	);

	ggd_neg_ln #(
		.FRAC_BITS    (FRAC_BITS),
		.UNIFORM_BITS (UNIFORM_BITS)
	) u_ln_b (
		.clk    (clk),
		.en     (adv),
		.word   (in_data.uniform_b),
		.neg_ln (nb)
	);

	// Tail stage 1: in shape 0.5 the two exponentials are summed.
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1 <= shape_mode_q ? SW'(na) + SW'(nb) : SW'(na);
		end
	end

	// Tail stage 2: multiply by the scale and round to nearest.
	assign scl_c = MPW'(sum_s1) * MPW'(scale_q) + (MPW'(1) << 15);

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s2 <= scl_c[16 +: YW];
		end
	end

	// Tail stage 3: partial products of the square.
	always_ff @(posedge clk) begin
		if (adv) begin
			hh_s3 <= (2*HH)'(y_s2[YW-1:HL]) * (2*HH)'(y_s2[YW-1:HL]);
			hl_s3 <= (HH+HL)'(y_s2[YW-1:HL]) * (HH+HL)'(y_s2[HL-1:0]);
			ll_s3 <= (2*HL)'(y_s2[HL-1:0]) * (2*HL)'(y_s2[HL-1:0]);
			y_s3  <= y_s2;
		end
	end

	// Tail stage 4: combine partial products and add the rounding half.
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s4 <= (QW'(hh_s3) << (2 * HL)) + (QW'(hl_s3) << (HL + 1))
				+ QW'(ll_s3) + (QW'(1) << (FRAC_BITS - 1));
			y_s4  <= y_s3;
		end
	end

	// Tail stage 5: pick the magnitude (the clipped square in shape 0.5), apply the sign.
	always_comb begin
		r_c   = sq_s4[QW-1:FRAC_BITS];
		sat_c = shape_mode_q && (|r_c[RQW-1:47]);
		if (!shape_mode_q) begin
			mag_c = 47'(y_s4);
		end else if (sat_c) begin
			mag_c = MAG_MAX;
		end else begin
			mag_c = r_c[46:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s5.sample    <= sign_s[N-2] ? SAMPLE_W'(mag_c) : -SAMPLE_W'(mag_c);
			out_s5.saturated <= sat_c;
			out_s5.last_out  <= last_s[N-2];
		end
	end

	assign out_valid = valid_s[N-1];
	assign out_data  = out_s5;

	// Only the squared mode can overflow the sample range.
	a_sat_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |-> shape_mode_q)
		else $error("saturation flagged in Laplace mode");

	// A saturated result carries the largest magnitude.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
		(out_data.sample == $signed({1'b0, MAG_MAX}) ||
		 out_data.sample == -$signed({1'b0, MAG_MAX})))
		else $error("saturated sample is not at the range limit");

	// A held pipeline keeps every valid bit.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(valid_s))
		else $error("pipeline moved while stalled");

	// Back pressure only comes from a held result.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

endmodule
